/* hdl/tbo_pkg.sv */
// ----------------------------------------------------------------------------
// tbo_pkg
// shared types, constants and helpers for the two-body orbit stepper
// ----------------------------------------------------------------------------
`default_nettype none

package tbo_pkg;

  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_H = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAV   = 8'd1;

  localparam logic [46:0] STEP_H_RST = 47'd4294967;
  localparam logic [46:0] GRAV_RST   = 47'd169558512490;

  // velocity load scale 365.25 = 1461/4
  localparam logic [10:0] LOAD_SCALE = 11'd1461;

  localparam logic [46:0] DIST_MAX = 47'h7FFF_FFFF_FFFF;
  localparam logic [48:0] DM_MAX   = 49'h1_0000_0000_0000;
  localparam logic [47:0] POS_MAX  = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] NEG_MIN  = 48'h8000_0000_0000;

  localparam logic [7:0] ITER_DIV  = 8'd128;
  localparam logic [7:0] ITER_SQRT = 8'd64;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_POS,
    ST_SQACC,
    ST_SQRT,
    ST_KSTORE,
    ST_UDIV,
    ST_USTORE,
    ST_NDIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic sqrt_mode;
  } dsq_req_t;

  typedef struct packed {
    logic [47:0] val;
    logic        ovf;
  } sat_t;

  function automatic logic [47:0] mag48(input logic [47:0] v);
    return v[47] ? 48'(~v + 48'd1) : v;
  endfunction

  // base +/- dm, clamped to 48-bit signed
  function automatic sat_t add_sat(input logic [47:0] base, input logic [48:0] dm,
                                   input logic sub);
    logic [50:0] b;
    logic [50:0] d;
    logic [50:0] s;
    sat_t r;
    b = {{3{base[47]}}, base};
    d = {2'b00, dm};
    s = sub ? 51'(b - d) : 51'(b + d);
    r.ovf = !((s[50:47] == 4'b0000) || (s[50:47] == 4'b1111));
    r.val = r.ovf ? (s[50] ? NEG_MIN : POS_MAX) : s[47:0];
    return r;
  endfunction

  // load velocity scale, rounded half away from zero, then clamped
  function automatic logic [47:0] load_scale(input logic [47:0] v);
    logic [58:0] p;
    logic [58:0] m;
    logic [58:0] s;
    p = 59'(mag48(v)) * 59'(LOAD_SCALE);
    m = {2'b00, 57'((p + 59'd2) >> 2)};
    s = v[47] ? 59'(~m + 59'd1) : m;
    if ((s[58:47] == 12'h000) || (s[58:47] == 12'hFFF)) begin
      return s[47:0];
    end
    return s[58] ? NEG_MIN : POS_MAX;
  endfunction

endpackage

`default_nettype wire

/* hdl/two_body_orbit_euler_step.sv */
// ----------------------------------------------------------------------------
// two_body_orbit_euler_step
// semi-implicit euler step of one body about the sun, signed q16.32 state
// ----------------------------------------------------------------------------
// load request: velocities scaled axis by axis in the load state, no result
// step request: time from accept to result is set by the shared
//   restoring divider (six divides) and the square root
// one request at a time: in_stall stays high until the sequencer is back in idle
// reset (rst, synchronous): position and velocity cleared, step_h and grav_const
//   back to defaults, no result pending
`default_nettype none

module two_body_orbit_euler_step (
  input  wire logic        clk,
  input  wire logic        rst,
  // input request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        op,
  input  wire logic [47:0] load_pos_x,
  input  wire logic [47:0] load_pos_y,
  input  wire logic [47:0] load_pos_z,
  input  wire logic [47:0] load_vel_x,
  input  wire logic [47:0] load_vel_y,
  input  wire logic [47:0] load_vel_z,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [47:0]      out_pos_x,
  output logic [47:0]      out_pos_y,
  output logic [47:0]      out_pos_z,
  output logic [47:0]      out_vel_x,
  output logic [47:0]      out_vel_y,
  output logic [47:0]      out_vel_z,
  output logic [46:0]      distance,
  output logic             fault,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [tbo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [46:0] cfg_data
);

  tbo_pkg::state_t state, state_next, ret;

  // configuration
  logic [46:0] step_h;
  logic [46:0] grav_const;

  // orbit state, one entry per axis
  logic [47:0] pos [3];
  logic [47:0] vel [3];
  logic [1:0]  ax;

  // shared 32x32 multiplier, four partial products into a 128-bit accumulator
  logic [63:0]  ma;
  logic [63:0]  mb;
  logic [2:0]   mcnt;
  logic [63:0]  prod_r;
  logic [1:0]   psh;
  logic [127:0] acc;
  logic [31:0]  mdig_a;
  logic [31:0]  mdig_b;

  // step scratch
  logic [127:0] sum;     // x^2+y^2+z^2
  logic [63:0]  root;    // floor sqrt of sum
  logic [63:0]  kq;      // rounded h*g
  logic         flt;

  // divider / square root unit
  tbo_pkg::dsq_req_t dsq_req;
  tbo_pkg::dsq_req_t dsq_req_next;
  logic [127:0]      dsq_num;
  logic [127:0]      dsq_den;
  logic              dsq_done;
  logic [127:0]      dsq_res;

  logic [47:0]   cur_pos;
  logic [47:0]   cur_vel;
  logic [48:0]   pos_dm;
  logic          pos_dm_ovf;
  logic [48:0]   vel_dm;
  logic          vel_dm_ovf;
  tbo_pkg::sat_t pos_upd;
  tbo_pkg::sat_t vel_upd;
  logic [1:0]    ax_inc;
  logic [47:0]   load_pos [3];
  logic [47:0]   load_vel [3];

  tbo_divsqrt u_divsqrt (
    .clk  (clk),
    .rst  (rst),
    .req  (dsq_req),
    .num  (dsq_num),
    .den  (dsq_den),
    .done (dsq_done),
    .res  (dsq_res)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != tbo_pkg::ST_IDLE);

  assign load_pos[0] = load_pos_x;
  assign load_pos[1] = load_pos_y;
  assign load_pos[2] = load_pos_z;
  assign load_vel[0] = load_vel_x;
  assign load_vel[1] = load_vel_y;
  assign load_vel[2] = load_vel_z;

  always_comb begin
    cur_pos = pos[ax];
    cur_vel = vel[ax];
    ax_inc  = ax + 2'd1;

    // position step: round(h*|v|/2^32), capped at 2^48
    pos_dm_ovf = (|acc[127:81]) || (acc[80:32] > tbo_pkg::DM_MAX);
    pos_dm     = pos_dm_ovf ? tbo_pkg::DM_MAX : acc[80:32];
    pos_upd    = tbo_pkg::add_sat(cur_pos, pos_dm, cur_vel[47]);

    // velocity kick from the second divide, capped at 2^48
    vel_dm_ovf = (|dsq_res[127:49]) || (dsq_res[48:0] > tbo_pkg::DM_MAX);
    vel_dm     = vel_dm_ovf ? tbo_pkg::DM_MAX : dsq_res[48:0];
    vel_upd    = tbo_pkg::add_sat(cur_vel, vel_dm, !cur_pos[47]);

    mdig_a = mcnt[0] ? ma[63:32] : ma[31:0];
    mdig_b = mcnt[1] ? mb[63:32] : mb[31:0];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tbo_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tbo_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = op ? tbo_pkg::ST_MUL : tbo_pkg::ST_LOAD;
        end
      end
      tbo_pkg::ST_LOAD: begin
        if (ax == 2'd2) begin
          state_next = tbo_pkg::ST_IDLE;
        end
      end
      tbo_pkg::ST_MUL: begin
        if (mcnt == 3'd4) begin
          state_next = ret;
        end
      end
      tbo_pkg::ST_POS:    state_next = tbo_pkg::ST_MUL;
      tbo_pkg::ST_SQACC:  state_next = (ax == 2'd2) ? tbo_pkg::ST_SQRT : tbo_pkg::ST_MUL;
      tbo_pkg::ST_SQRT: begin
        if (dsq_done) begin
          state_next = (sum == '0) ? tbo_pkg::ST_DONE : tbo_pkg::ST_MUL;
        end
      end
      tbo_pkg::ST_KSTORE: state_next = tbo_pkg::ST_UDIV;
      tbo_pkg::ST_UDIV: begin
        if (dsq_done) begin
          state_next = tbo_pkg::ST_MUL;
        end
      end
      tbo_pkg::ST_USTORE: state_next = tbo_pkg::ST_NDIV;
      tbo_pkg::ST_NDIV: begin
        if (dsq_done) begin
          state_next = (ax == 2'd2) ? tbo_pkg::ST_DONE : tbo_pkg::ST_UDIV;
        end
      end
      tbo_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = tbo_pkg::ST_IDLE;
        end
      end
      default: state_next = tbo_pkg::ST_IDLE;
    endcase
  end

  // divider start pulses: square root after the last square, then the
  // per-axis u and kick divides
  always_comb begin
    dsq_req_next = '0;
    if ((state == tbo_pkg::ST_SQACC) && (ax == 2'd2)) begin
      dsq_req_next = '{start: 1'b1, sqrt_mode: 1'b1};
    end else if ((state == tbo_pkg::ST_KSTORE) || (state == tbo_pkg::ST_USTORE) ||
                 ((state == tbo_pkg::ST_NDIV) && dsq_done && (ax != 2'd2))) begin
      dsq_req_next = '{start: 1'b1, sqrt_mode: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dsq_req <= '0;
    end else begin
      dsq_req <= dsq_req_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_h     <= tbo_pkg::STEP_H_RST;
      grav_const <= tbo_pkg::GRAV_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == tbo_pkg::CFG_STEP_H) begin
        step_h <= cfg_data;
      end else if (cfg_index == tbo_pkg::CFG_GRAV) begin
        grav_const <= cfg_data;
      end
    end
  end

  // orbit state and step datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        pos[i] <= '0;
        vel[i] <= '0;
      end
      ax      <= '0;
      mcnt    <= '0;
      ret     <= tbo_pkg::ST_IDLE;
      flt     <= 1'b0;
    end else begin
      case (state)
        tbo_pkg::ST_IDLE: begin
          ax <= '0;
          if (in_valid) begin
            if (!op) begin
              for (int i = 0; i < 3; i++) begin
                pos[i] <= load_pos[i];
                vel[i] <= load_vel[i];
              end
            end else begin
              // h*|v| + half lsb for the first axis
              flt  <= 1'b0;
              sum  <= '0;
              ma   <= {17'd0, step_h};
              mb   <= {16'd0, tbo_pkg::mag48(vel[0])};
              acc  <= 128'h8000_0000;
              mcnt <= '0;
              ret  <= tbo_pkg::ST_POS;
            end
          end
        end
        tbo_pkg::ST_LOAD: begin
          vel[ax] <= tbo_pkg::load_scale(vel[ax]);
          ax      <= ax_inc;
        end
        tbo_pkg::ST_MUL: begin
          if (mcnt != 3'd4) begin
            prod_r <= mdig_a * mdig_b;
            psh    <= {1'b0, mcnt[0]} + {1'b0, mcnt[1]};
          end
          if (mcnt != 3'd0) begin
            acc <= acc + ({64'd0, prod_r} << {psh, 5'd0});
          end
          mcnt <= mcnt + 3'd1;
        end
        tbo_pkg::ST_POS: begin
          pos[ax] <= pos_upd.val;
          flt     <= flt | pos_upd.ovf | pos_dm_ovf;
          ma      <= {16'd0, tbo_pkg::mag48(pos_upd.val)};
          mb      <= {16'd0, tbo_pkg::mag48(pos_upd.val)};
          acc     <= '0;
          mcnt    <= '0;
          ret     <= tbo_pkg::ST_SQACC;
        end
        tbo_pkg::ST_SQACC: begin
          sum <= sum + acc;
          if (ax == 2'd2) begin
            dsq_num <= sum + acc;
          end else begin
            ax   <= ax_inc;
            ma   <= {17'd0, step_h};
            mb   <= {16'd0, tbo_pkg::mag48(vel[ax_inc])};
            acc  <= 128'h8000_0000;
            mcnt <= '0;
            ret  <= tbo_pkg::ST_POS;
          end
        end
        tbo_pkg::ST_SQRT: begin
          if (dsq_done) begin
            root <= dsq_res[63:0];
            if (sum == '0) begin
              flt <= 1'b1;
            end
            // round(h*g / 2^32)
            ma   <= {17'd0, step_h};
            mb   <= {17'd0, grav_const};
            acc  <= 128'h8000_0000;
            mcnt <= '0;
            ret  <= tbo_pkg::ST_KSTORE;
          end
        end
        tbo_pkg::ST_KSTORE: begin
          kq      <= acc[95:32];
          ax      <= '0;
          dsq_num <= {48'd0, tbo_pkg::mag48(pos[0]), 32'd0};
          dsq_den <= {64'd0, root};
        end
        tbo_pkg::ST_UDIV: begin
          if (dsq_done) begin
            ma   <= kq;
            mb   <= dsq_res[63:0];
            acc  <= '0;
            mcnt <= '0;
            ret  <= tbo_pkg::ST_USTORE;
          end
        end
        tbo_pkg::ST_USTORE: begin
          dsq_num <= {acc[95:0], 32'd0};
          dsq_den <= sum;
        end
        tbo_pkg::ST_NDIV: begin
          if (dsq_done) begin
            vel[ax] <= vel_upd.val;
            flt     <= flt | vel_upd.ovf | vel_dm_ovf;
            if (ax != 2'd2) begin
              ax      <= ax_inc;
              dsq_num <= {48'd0, tbo_pkg::mag48(pos[ax_inc]), 32'd0};
              dsq_den <= {64'd0, root};
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == tbo_pkg::ST_DONE) && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == tbo_pkg::ST_DONE) && (!out_valid || !out_stall)) begin
      out_pos_x <= pos[0];
      out_pos_y <= pos[1];
      out_pos_z <= pos[2];
      out_vel_x <= vel[0];
      out_vel_y <= vel[1];
      out_vel_z <= vel[2];
      // distance beyond 47 bits clamps and flags
      if (|root[63:47]) begin
        distance <= tbo_pkg::DIST_MAX;
        fault    <= 1'b1;
      end else begin
        distance <= root[46:0];
        fault    <= flt;
      end
    end
  end

  // a new result only ever comes out of the finish state
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == tbo_pkg::ST_DONE))
    else $error("result raised outside finish state");

  // divider completions arrive only while the sequencer waits on them
  assert property (@(posedge clk) disable iff (rst)
    dsq_done |-> (state == tbo_pkg::ST_SQRT || state == tbo_pkg::ST_UDIV ||
                  state == tbo_pkg::ST_NDIV))
    else $error("divider done while sequencer not waiting");

  // multiply sequence never runs past its last partial product
  assert property (@(posedge clk) disable iff (rst)
    (state == tbo_pkg::ST_MUL) |-> (mcnt <= 3'd4))
    else $error("multiply counter overrun");

endmodule

`default_nettype wire

/* hdl/tbo_divsqrt.sv */
// ----------------------------------------------------------------------------
// tbo_divsqrt
// shared restoring divider and integer square root, one bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module tbo_divsqrt (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire tbo_pkg::dsq_req_t req,
  input  wire logic [127:0]     num,
  input  wire logic [127:0]     den,
  output logic                  done,
  output logic [127:0]          res
);

  logic         busy;
  logic         sqm;
  logic [7:0]   cnt;
  logic [127:0] ra;   // remainder
  logic [127:0] rq;   // quotient or root
  logic [127:0] rs;   // shifting numerator or root bit
  logic [127:0] rd;   // divisor

  logic [127:0] cand;
  logic [127:0] cmpb;
  logic [127:0] diff;
  logic         ge;

  // one shared compare and subtract
  always_comb begin
    cand = sqm ? ra : {ra[126:0], rs[127]};
    cmpb = sqm ? (rq | rs) : rd;
    ge   = (cand >= cmpb);
    diff = cand - cmpb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.sqrt_mode ? tbo_pkg::ITER_SQRT : tbo_pkg::ITER_DIV;
      end else if (busy) begin
        cnt <= cnt - 8'd1;
        if (cnt == 8'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      sqm <= req.sqrt_mode;
      rd  <= den;
      rq  <= '0;
      if (req.sqrt_mode) begin
        ra <= num;
        rs <= 128'h4000_0000_0000_0000_0000_0000_0000_0000;
      end else begin
        ra <= '0;
        rs <= num;
      end
    end else if (busy) begin
      if (sqm) begin
        ra <= ge ? diff : ra;
        rq <= ge ? ((rq >> 1) | rs) : (rq >> 1);
        rs <= rs >> 2;
      end else begin
        ra <= ge ? diff : cand;
        rq <= {rq[126:0], ge};
        rs <= {rs[126:0], 1'b0};
      end
    end
  end

  assign res = rq;

endmodule

`default_nettype wire
